// ----- rtl/matrix_sort_plus_transpose_core_assert.svh -----
// assertion macros for the matrix sort plus transpose core
`ifndef MATRIX_SORT_PLUS_TRANSPOSE_CORE_ASSERT_SVH
`define MATRIX_SORT_PLUS_TRANSPOSE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define MSPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// clocked check that also holds during reset
`define MSPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MSPT_ASSERT(lbl, prop, msg)
`define MSPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/mspt_pkg.sv -----
// shared types, constants and helpers for the matrix sort plus transpose core
`default_nettype none
package mspt_pkg;

  localparam int unsigned MAX_DIM     = 8;
  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_DIM);
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned SUM_W       = DATA_W + 1;
  localparam int unsigned STEP_W      = $clog2(STORE_DEPTH + 2);

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  // clamp a raw dim write into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] active_dim(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] d;
    d = raw;
    if (d == '0) begin
      d = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  // element count of a dim by dim matrix
  function automatic logic [CNT_W-1:0] dim_square(input logic [DIM_W-1:0] d);
    logic [2*DIM_W-1:0] p;
    p = d * d;
    return p[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mspt_ram.sv -----
// generic ram: one write port, two registered read ports
`default_nettype none
module mspt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// ----- rtl/matrix_sort_plus_transpose_core.sv -----
// top level: loads a square matrix, sorts it, streams sorted/transposed pairs
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+-------------------------
//  element   | start_i, busy_o, element_i               | taken when start & !busy
//  config    | cfg_valid_i, cfg_ready_o, cfg_dim_i      | taken when valid & ready
//  result    | res_valid_o, sorted_value_o,             | one-cycle strobe, no stall
//            | transposed_value_o, pair_sum_o, final_res_o |
//
// loading takes at most one element per cycle; busy stays low until the last one,
// except while a config write is offered.
// with N = dim*dim the sort is a bubble sort over the store memory, pass by pass,
// using one compare/select unit and one read port of the memory.
// the N results then follow one per cycle, through the store read and result registers.
// a config write clears the partial load; reset gives dim 8, store contents undefined.
// the receiver cannot stall: results are never held back.
`default_nettype none
`include "matrix_sort_plus_transpose_core_assert.svh"
module matrix_sort_plus_transpose_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [mspt_pkg::DATA_W-1:0]  element_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [mspt_pkg::DIM_W-1:0]   cfg_dim_i,
  output logic                                     res_valid_o,
  output logic signed      [mspt_pkg::DATA_W-1:0]  sorted_value_o,
  output logic signed      [mspt_pkg::DATA_W-1:0]  transposed_value_o,
  output logic signed      [mspt_pkg::SUM_W-1:0]   pair_sum_o,
  output logic                                     final_res_o
);

  mspt_pkg::state_e                 state_q, state_d;
  logic [mspt_pkg::DIM_W-1:0]       dim_q, dim_d;
  logic [mspt_pkg::CNT_W-1:0]       total_q, total_d;
  logic [mspt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [mspt_pkg::ADDR_W-1:0]      pass_last_q, pass_last_d;
  logic [mspt_pkg::STEP_W-1:0]      step_q, step_d;
  logic [mspt_pkg::DATA_W-1:0]      cur_q, cur_d;
  logic [mspt_pkg::IDX_W-1:0]       row_q, row_d, col_q, col_d;
  logic [mspt_pkg::ADDR_W-1:0]      addr_a_q, addr_a_d, addr_b_q, addr_b_d;
  logic                             rd_vld_q, rd_last_q;
  logic                             res_vld_q, res_last_q;
  logic [mspt_pkg::DATA_W-1:0]      res_b_q, res_c_q;
  logic [mspt_pkg::SUM_W-1:0]       res_sum_q;

  logic                             cfg_req, elem_req;
  logic                             ram_we;
  logic [mspt_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr_a;
  logic [mspt_pkg::DATA_W-1:0]      ram_wdata, ram_rdata_a, ram_rdata_b;
  logic [mspt_pkg::IDX_W-1:0]       dim_m1;
  logic [mspt_pkg::STEP_W-1:0]      pass_end;
  logic                             out_last;
  logic                             rd_less;

  // handshakes
  assign cfg_ready_o = (state_q == mspt_pkg::ST_LOAD);
  assign cfg_req     = cfg_valid_i & cfg_ready_o;
  assign busy_o      = (state_q != mspt_pkg::ST_LOAD) | cfg_valid_i;
  assign elem_req    = start_i & ~busy_o;

  assign dim_m1   = mspt_pkg::IDX_W'(dim_q - mspt_pkg::DIM_W'(1));
  assign out_last = (row_q == dim_m1) & (col_q == dim_m1);
  assign pass_end = mspt_pkg::STEP_W'(pass_last_q) + mspt_pkg::STEP_W'(2);
  // shared compare unit: incoming word against the carried maximum
  assign rd_less  = $signed(ram_rdata_a) < $signed(cur_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    pass_last_d = pass_last_q;
    step_d      = step_q;
    cur_d       = cur_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_a_d    = addr_a_q;
    addr_b_d    = addr_b_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[mspt_pkg::ADDR_W-1:0];
    ram_wdata   = element_i;
    ram_raddr_a = addr_a_q;
    unique case (state_q)
      mspt_pkg::ST_LOAD: begin
        if (cfg_req) begin
          dim_d   = mspt_pkg::active_dim(cfg_dim_i);
          total_d = mspt_pkg::dim_square(mspt_pkg::active_dim(cfg_dim_i));
          cnt_d   = '0;
        end else if (elem_req) begin
          ram_we = 1'b1;
          if (cnt_q + mspt_pkg::CNT_W'(1) == total_q) begin
            cnt_d       = '0;
            state_d     = mspt_pkg::ST_SORT;
            pass_last_d = mspt_pkg::ADDR_W'(total_q - mspt_pkg::CNT_W'(1));
            step_d      = '0;
          end else begin
            cnt_d = cnt_q + mspt_pkg::CNT_W'(1);
          end
        end
      end
      mspt_pkg::ST_SORT: begin
        ram_raddr_a = step_q[mspt_pkg::ADDR_W-1:0];
        if (pass_last_q == '0) begin
          // sorted: set up the output walk
          state_d  = mspt_pkg::ST_OUT;
          row_d    = '0;
          col_d    = '0;
          addr_a_d = '0;
          addr_b_d = '0;
        end else if (step_q == pass_end) begin
          // close the pass with the carried maximum
          ram_we      = 1'b1;
          ram_waddr   = pass_last_q;
          ram_wdata   = cur_q;
          pass_last_d = pass_last_q - mspt_pkg::ADDR_W'(1);
          step_d      = '0;
        end else begin
          step_d = step_q + mspt_pkg::STEP_W'(1);
          if (step_q == mspt_pkg::STEP_W'(1)) begin
            cur_d = ram_rdata_a;
          end else if (step_q != '0) begin
            ram_we    = 1'b1;
            ram_waddr = mspt_pkg::ADDR_W'(step_q - mspt_pkg::STEP_W'(2));
            if (rd_less) begin
              ram_wdata = ram_rdata_a;
            end else begin
              ram_wdata = cur_q;
              cur_d     = ram_rdata_a;
            end
          end
        end
      end
      mspt_pkg::ST_OUT: begin
        addr_a_d = addr_a_q + mspt_pkg::ADDR_W'(1);
        if (col_q == dim_m1) begin
          col_d    = '0;
          row_d    = row_q + mspt_pkg::IDX_W'(1);
          addr_b_d = mspt_pkg::ADDR_W'(row_q) + mspt_pkg::ADDR_W'(1);
        end else begin
          col_d    = col_q + mspt_pkg::IDX_W'(1);
          addr_b_d = addr_b_q + mspt_pkg::ADDR_W'(dim_q);
        end
        if (out_last) begin
          state_d = mspt_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = mspt_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mspt_pkg::ST_LOAD;
      dim_q       <= mspt_pkg::DIM_W'(mspt_pkg::MAX_DIM);
      total_q     <= mspt_pkg::CNT_W'(mspt_pkg::STORE_DEPTH);
      cnt_q       <= '0;
      pass_last_q <= '0;
      step_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      addr_a_q    <= '0;
      addr_b_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      res_vld_q   <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      dim_q       <= dim_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      pass_last_q <= pass_last_d;
      step_q      <= step_d;
      row_q       <= row_d;
      col_q       <= col_d;
      addr_a_q    <= addr_a_d;
      addr_b_q    <= addr_b_d;
      rd_vld_q    <= (state_q == mspt_pkg::ST_OUT);
      rd_last_q   <= (state_q == mspt_pkg::ST_OUT) & out_last;
      res_vld_q   <= rd_vld_q;
      res_last_q  <= rd_last_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (rd_vld_q) begin
      res_b_q   <= ram_rdata_a;
      res_c_q   <= ram_rdata_b;
      res_sum_q <= {ram_rdata_a[mspt_pkg::DATA_W-1], ram_rdata_a}
                 + {ram_rdata_b[mspt_pkg::DATA_W-1], ram_rdata_b};
    end
  end

  // value store
  mspt_ram #(
    .WIDTH (mspt_pkg::DATA_W),
    .DEPTH (mspt_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (addr_b_q),
    .rdata_b_o (ram_rdata_b)
  );

  // result ports
  assign res_valid_o        = res_vld_q;
  assign final_res_o        = res_last_q;
  assign sorted_value_o     = res_b_q;
  assign transposed_value_o = res_c_q;
  assign pair_sum_o         = res_sum_q;

  // checks
  `MSPT_ASSERT(a_cnt_in_range,
               (state_q == mspt_pkg::ST_LOAD) |-> (cnt_q < total_q),
               "load count past matrix size")
  `MSPT_ASSERT(a_final_has_strobe, final_res_o |-> res_valid_o,
               "final flag without result strobe")
  `MSPT_ASSERT(a_final_ends_burst, final_res_o |=> !res_valid_o,
               "result strobe right after final")
  `MSPT_ASSERT(a_out_after_sort,
               (state_q == mspt_pkg::ST_OUT) |-> ($past(state_q) != mspt_pkg::ST_LOAD),
               "output walk started without sort")
  `MSPT_ASSERT_ALWAYS(a_no_strobe_in_reset, !rst_ni |=> !res_valid_o,
                      "result strobe during reset")

endmodule
`default_nettype wire
